/* hdl/scc_labeler_two_pass_dfs_macros.svh */
// Assertion macros shared by the labeler RTL.
`ifndef SCC_LABELER_TWO_PASS_DFS_MACROS_SVH
`define SCC_LABELER_TWO_PASS_DFS_MACROS_SVH

// Checked only outside reset.
`define SCC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SCC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/scc_pkg.sv */
// Types and constants of the SCC labeler.
package scc_pkg;

    localparam int NODE_W  = 6;
    localparam int LABEL_W = 7;
    localparam int CNT_W   = 7;

    localparam logic       CMD_ADD_EDGE = 1'b0;
    localparam logic       CMD_RUN      = 1'b1;

    localparam logic       CFG_NODE_COUNT  = 1'b0;
    localparam logic       CFG_FIRST_LABEL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_ROOT,
        ST_F_CHECK,
        ST_F_RD,
        ST_F_SCAN,
        ST_R_INIT,
        ST_R_NEXT,
        ST_R_FRD,
        ST_R_POP,
        ST_R_PRD,
        ST_R_SCAN,
        ST_E_RD,
        ST_E_OUT
    } t_state;

endpackage

/* hdl/scc_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
module scc_ram
    import scc_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* hdl/scc_labeler_two_pass_dfs.sv */
// Top level of the strongly connected component labeler (Kosaraju, two passes).
//
// Input stream (s_axis): one word per command. tuser = cmd; 0 adds the edge in
// tdata, 1 starts a labeling run. Add words are taken one per cycle while idle;
// an edge with an endpoint not below the node count, or one beyond the store
// capacity, is dropped and the drop flag is set.
// Output stream (m_axis): after a run, one word per node in node order, tdata =
// node index and component label, tlast on the final node, tuser = drop flag.
// Config port: write node_count (index 0) or first_label (index 1), idle only.
// Run steps: pass one visits each node by root check, open, a scan of every
// stored edge, then finish and stack pop; stale stack entries are popped as
// well. The edge store has a single read port and the shared edge compare
// looks at one edge per cycle. Pass two visits each node by finish-order read,
// pop and a scan of every stored edge, and steps the label after each component.
// Emission reads each node's label, then holds the word until it is taken.
// tready on the input is high only while idle. A stalled receiver holds the
// current result word; the block waits. After the last word the edge store
// and drop flag are cleared. Synchronous reset returns to idle, empty store,
// node_count 64, first_label 0; no clearing pass is needed.
module scc_labeler_two_pass_dfs
    import scc_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_wdata,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [5:0] edge_source, [11:6] edge_target
    input  logic        s_axis_tuser,   // [0] cmd
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] node_index, [12:6] component
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] dropped
);

`include "scc_labeler_two_pass_dfs_macros.svh"

    localparam int SD    = MAX_NODES + MAX_EDGES;      // stack depth
    localparam int SA_W  = $clog2(SD);
    localparam int SP_W  = $clog2(SD + 1);
    localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W  = $clog2(MAX_EDGES + 1);
    localparam int NI_W  = $clog2(MAX_NODES);
    localparam int EW    = 2 * NODE_W;

    t_state r_state, n_state;

    // config
    logic [CNT_W-1:0]   r_node_count;
    logic [NODE_W-1:0]  r_first_label;

    // control
    logic [EC_W-1:0]    r_edge_total, n_edge_total;
    logic               r_drop, n_drop;
    logic [MAX_NODES-1:0] r_seen, n_seen;
    logic [MAX_NODES-1:0] r_done, n_done;
    logic [SP_W-1:0]    r_sp, n_sp;
    logic [CNT_W-1:0]   r_root, n_root;
    logic [CNT_W-1:0]   r_order, n_order;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [LABEL_W-1:0] r_label, n_label;
    logic [EC_W-1:0]    r_eaddr, n_eaddr;
    logic               r_evld, n_evld;
    logic [NODE_W-1:0]  r_v, n_v;
    logic [NODE_W-1:0]  r_top, n_top;

    // memory ports
    logic               edge_we, edge_re;
    logic [EA_W-1:0]    edge_waddr, edge_raddr;
    logic [EW-1:0]      edge_wdata, edge_q;
    logic               stk_we, stk_re;
    logic [SA_W-1:0]    stk_waddr, stk_raddr;
    logic [NODE_W-1:0]  stk_wdata, stk_q;
    logic               fin_we, fin_re;
    logic [NI_W-1:0]    fin_waddr, fin_raddr;
    logic [NODE_W-1:0]  fin_wdata, fin_q;
    logic               lbl_we, lbl_re;
    logic [NI_W-1:0]    lbl_waddr, lbl_raddr;
    logic [LABEL_W-1:0] lbl_wdata, lbl_q;

    // datapath helpers
    logic [CNT_W-1:0]   w_n;
    logic [NODE_W-1:0]  in_src, in_dst, e_src, e_dst;
    logic               e_in_range, scan_issue, scan_done, push_ok, is_last;

    scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(EW)) u_edge_ram (
        .i_clk, .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_re(edge_re), .i_raddr(edge_raddr), .o_rdata(edge_q)
    );
    scc_ram #(.DEPTH(SD), .WIDTH(NODE_W)) u_stack_ram (
        .i_clk, .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(stk_re), .i_raddr(stk_raddr), .o_rdata(stk_q)
    );
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_finish_ram (
        .i_clk, .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(fin_wdata),
        .i_re(fin_re), .i_raddr(fin_raddr), .o_rdata(fin_q)
    );
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(LABEL_W)) u_label_ram (
        .i_clk, .i_we(lbl_we), .i_waddr(lbl_waddr), .i_wdata(lbl_wdata),
        .i_re(lbl_re), .i_raddr(lbl_raddr), .o_rdata(lbl_q)
    );

    // effective node count: 0 acts as 1, clamp at MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            w_n = CNT_W'(1);
        end else if (r_node_count > CNT_W'(MAX_NODES)) begin
            w_n = CNT_W'(MAX_NODES);
        end else begin
            w_n = r_node_count;
        end
    end

    assign in_src     = s_axis_tdata[NODE_W-1:0];
    assign in_dst     = s_axis_tdata[EW-1:NODE_W];
    assign e_src      = edge_q[NODE_W-1:0];
    assign e_dst      = edge_q[EW-1:NODE_W];
    assign e_in_range = ({1'b0, e_src} < w_n) && ({1'b0, e_dst} < w_n);
    assign scan_issue = r_eaddr < r_edge_total;
    assign scan_done  = !scan_issue && !r_evld;
    assign push_ok    = r_sp < SP_W'(SD);
    assign is_last    = (r_root + CNT_W'(1)) == w_n;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_E_OUT);
    assign m_axis_tdata  = {3'b000, lbl_q, r_root[NODE_W-1:0]};
    assign m_axis_tlast  = is_last;
    assign m_axis_tuser  = r_drop;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= CNT_W'(64);
            r_first_label <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_wdata;
            end else begin
                r_first_label <= i_cfg_wdata[NODE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_edge_total <= '0;
            r_drop       <= 1'b0;
            r_seen       <= '0;
            r_done       <= '0;
            r_sp         <= '0;
            r_root       <= '0;
            r_order      <= '0;
            r_idx        <= '0;
            r_label      <= '0;
            r_eaddr      <= '0;
            r_evld       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_total <= n_edge_total;
            r_drop       <= n_drop;
            r_seen       <= n_seen;
            r_done       <= n_done;
            r_sp         <= n_sp;
            r_root       <= n_root;
            r_order      <= n_order;
            r_idx        <= n_idx;
            r_label      <= n_label;
            r_eaddr      <= n_eaddr;
            r_evld       <= n_evld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_top <= n_top;
    end

    always_comb begin
        n_state      = r_state;
        n_edge_total = r_edge_total;
        n_drop       = r_drop;
        n_seen       = r_seen;
        n_done       = r_done;
        n_sp         = r_sp;
        n_root       = r_root;
        n_order      = r_order;
        n_idx        = r_idx;
        n_label      = r_label;
        n_eaddr      = r_eaddr;
        n_evld       = r_evld;
        n_v          = r_v;
        n_top        = r_top;

        edge_we    = 1'b0;
        edge_waddr = r_edge_total[EA_W-1:0];
        edge_wdata = {in_dst, in_src};
        edge_re    = 1'b0;
        edge_raddr = r_eaddr[EA_W-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_sp[SA_W-1:0];
        stk_wdata  = r_v;
        stk_re     = 1'b0;
        stk_raddr  = SA_W'(r_sp - SP_W'(1));
        fin_we     = 1'b0;
        fin_waddr  = r_order[NI_W-1:0];
        fin_wdata  = r_v;
        fin_re     = 1'b0;
        fin_raddr  = NI_W'(r_idx - CNT_W'(1));
        lbl_we     = 1'b0;
        lbl_waddr  = r_v[NI_W-1:0];
        lbl_wdata  = r_label;
        lbl_re     = 1'b0;
        lbl_raddr  = r_root[NI_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == CMD_ADD_EDGE) begin
                        if (({1'b0, in_src} >= w_n) || ({1'b0, in_dst} >= w_n) ||
                            (r_edge_total >= EC_W'(MAX_EDGES))) begin
                            n_drop = 1'b1;
                        end else begin
                            edge_we      = 1'b1;
                            n_edge_total = r_edge_total + EC_W'(1);
                        end
                    end else begin
                        n_seen  = '0;
                        n_done  = '0;
                        n_order = '0;
                        n_root  = '0;
                        n_sp    = '0;
                        n_state = ST_F_ROOT;
                    end
                end
            end

            // pass one: roots in index order
            ST_F_ROOT: begin
                if (r_root >= w_n) begin
                    n_state = ST_R_INIT;
                end else if (r_seen[r_root[NI_W-1:0]]) begin
                    n_root = r_root + CNT_W'(1);
                end else begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = r_root[NODE_W-1:0];
                    n_sp      = SP_W'(1);
                    n_v       = r_root[NODE_W-1:0];
                    n_state   = ST_F_CHECK;
                end
            end

            ST_F_CHECK: begin
                if (r_seen[r_v[NI_W-1:0]]) begin
                    if (!r_done[r_v[NI_W-1:0]] && (r_order < CNT_W'(MAX_NODES))) begin
                        fin_we  = 1'b1;
                        n_order = r_order + CNT_W'(1);
                    end
                    n_done[r_v[NI_W-1:0]] = 1'b1;
                    n_sp = r_sp - SP_W'(1);
                    if (r_sp == SP_W'(1)) begin
                        n_root  = r_root + CNT_W'(1);
                        n_state = ST_F_ROOT;
                    end else begin
                        stk_re    = 1'b1;
                        stk_raddr = SA_W'(r_sp - SP_W'(2));
                        n_state   = ST_F_RD;
                    end
                end else begin
                    n_seen[r_v[NI_W-1:0]] = 1'b1;
                    n_top   = r_v;
                    n_eaddr = '0;
                    n_evld  = 1'b0;
                    n_state = ST_F_SCAN;
                end
            end

            ST_F_RD: begin
                n_v     = stk_q;
                n_state = ST_F_CHECK;
            end

            // forward edges out of r_v, pushed in store order
            ST_F_SCAN: begin
                edge_re = scan_issue;
                n_evld  = scan_issue;
                if (scan_issue) begin
                    n_eaddr = r_eaddr + EC_W'(1);
                end
                if (r_evld && e_in_range && (e_src == r_v) &&
                    !r_seen[e_dst[NI_W-1:0]] && push_ok) begin
                    stk_we    = 1'b1;
                    stk_wdata = e_dst;
                    n_sp      = r_sp + SP_W'(1);
                    n_top     = e_dst;
                end
                if (scan_done) begin
                    n_v     = r_top;
                    n_state = ST_F_CHECK;
                end
            end

            // pass two: reverse finish order
            ST_R_INIT: begin
                n_seen  = '0;
                n_idx   = r_order;
                n_label = {1'b0, r_first_label};
                n_sp    = '0;
                n_state = ST_R_NEXT;
            end

            ST_R_NEXT: begin
                if (r_idx == '0) begin
                    n_root  = '0;
                    n_state = ST_E_RD;
                end else begin
                    fin_re  = 1'b1;
                    n_state = ST_R_FRD;
                end
            end

            ST_R_FRD: begin
                if (r_seen[fin_q[NI_W-1:0]]) begin
                    n_idx   = r_idx - CNT_W'(1);
                    n_state = ST_R_NEXT;
                end else begin
                    n_seen[fin_q[NI_W-1:0]] = 1'b1;
                    lbl_we    = 1'b1;
                    lbl_waddr = fin_q[NI_W-1:0];
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = fin_q;
                    n_sp      = SP_W'(1);
                    n_state   = ST_R_POP;
                end
            end

            ST_R_POP: begin
                if (r_sp == '0) begin
                    n_label = r_label + LABEL_W'(1);
                    n_idx   = r_idx - CNT_W'(1);
                    n_state = ST_R_NEXT;
                end else begin
                    stk_re  = 1'b1;
                    n_sp    = r_sp - SP_W'(1);
                    n_state = ST_R_PRD;
                end
            end

            ST_R_PRD: begin
                n_v     = stk_q;
                n_eaddr = '0;
                n_evld  = 1'b0;
                n_state = ST_R_SCAN;
            end

            // reverse edges into r_v: label and push each free source
            ST_R_SCAN: begin
                edge_re = scan_issue;
                n_evld  = scan_issue;
                if (scan_issue) begin
                    n_eaddr = r_eaddr + EC_W'(1);
                end
                if (r_evld && e_in_range && (e_dst == r_v) &&
                    !r_seen[e_src[NI_W-1:0]] && push_ok) begin
                    n_seen[e_src[NI_W-1:0]] = 1'b1;
                    lbl_we    = 1'b1;
                    lbl_waddr = e_src[NI_W-1:0];
                    stk_we    = 1'b1;
                    stk_wdata = e_src;
                    n_sp      = r_sp + SP_W'(1);
                end
                if (scan_done) begin
                    n_state = ST_R_POP;
                end
            end

            ST_E_RD: begin
                lbl_re  = 1'b1;
                n_state = ST_E_OUT;
            end

            ST_E_OUT: begin
                if (m_axis_tready) begin
                    if (is_last) begin
                        n_edge_total = '0;
                        n_drop       = 1'b0;
                        n_state      = ST_IDLE;
                    end else begin
                        n_root  = r_root + CNT_W'(1);
                        n_state = ST_E_RD;
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    `SCC_ASSERT(a_stack_bound, (r_sp <= SP_W'(SD)), "search stack overflow")
    `SCC_ASSERT(a_order_bound, (r_order <= CNT_W'(MAX_NODES)), "finish order overflow")
    `SCC_ASSERT(a_run_clears, (m_axis_tvalid && m_axis_tready && m_axis_tlast |=> (r_edge_total == '0) && !r_drop), "store not cleared after run")
    `SCC_ASSERT(a_one_side, !(s_axis_tready && m_axis_tvalid), "input ready while result pending")
    `SCC_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n |=> (r_state == ST_IDLE)), "not idle after reset")

endmodule
